// File: hdl/srtf_pkg.sv
package srtf_pkg;

    localparam int TASK_SLOTS = 16;
    localparam int TIME_BITS  = 24;
    localparam int IDX_BITS   = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
    localparam int BURST_BITS = 16;
    localparam int CALC_BITS  = (TIME_BITS > BURST_BITS) ? TIME_BITS : BURST_BITS;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_TICK = 1'b1;

    typedef struct packed {
        logic        opcode;
        logic [3:0]  slot;
        logic [23:0] arrival;
        logic [15:0] burst;
    } in_item_t;

    typedef struct packed {
        logic [23:0] tick_start;
        logic [3:0]  running;
        logic        idle;
        logic        finished;
        logic [23:0] completion;
        logic [23:0] turnaround;
        logic [23:0] waiting;
        logic        all_done;
    } out_item_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_UPDATE,
        ST_REPORT
    } state_t;

    typedef struct packed {
        logic load;
        logic tick_begin;
        logic scan;
        logic update;
        logic report;
    } ctrl_cmd_t;

    typedef struct packed {
        logic scan_last;
        logic out_free;
    } ctrl_status_t;

endpackage

// File: hdl/srtf_ctrl.sv
module srtf_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  in_valid,
    input  logic                  in_opcode,
    output logic                  in_ready,
    input  srtf_pkg::ctrl_status_t status,
    output srtf_pkg::ctrl_cmd_t   cmd
);
    import srtf_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    if (in_opcode == OP_TICK) begin
                        cmd.tick_begin = 1'b1;
                        state_next     = ST_SCAN;
                    end else begin
                        cmd.load = 1'b1;
                    end
                end
            end
            ST_SCAN: begin
                cmd.scan = 1'b1;
                if (status.scan_last) begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                cmd.update = 1'b1;
                state_next = ST_REPORT;
            end
            ST_REPORT: begin
                // hold the finished result until the output register frees up
                if (status.out_free) begin
                    cmd.report = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_UPDATE |=> state_reg == ST_REPORT)
        else $error("update not followed by report");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN && !status.scan_last) |=> state_reg == ST_SCAN)
        else $error("scan left early");

    assert property (@(posedge aclk) disable iff (!aresetn)
        in_ready |-> state_reg == ST_IDLE)
        else $error("input taken while busy");

endmodule

// File: hdl/srtf_datapath.sv
module srtf_datapath (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  srtf_pkg::in_item_t     in_data,
    input  srtf_pkg::ctrl_cmd_t    cmd,
    output srtf_pkg::ctrl_status_t status,
    output logic                   out_valid,
    input  logic                   out_ready,
    output srtf_pkg::out_item_t    out_data
);
    import srtf_pkg::*;

    localparam logic [TIME_BITS-1:0] TIME_MAX = '1;
    localparam logic [IDX_BITS-1:0]  IDX_LAST = IDX_BITS'(TASK_SLOTS - 1);

    logic [TASK_SLOTS-1:0] valid_reg;
    logic [TASK_SLOTS-1:0] pending_reg;
    logic [TIME_BITS-1:0]  arrival_mem [TASK_SLOTS];
    logic [BURST_BITS-1:0] burst_mem [TASK_SLOTS];
    logic [BURST_BITS-1:0] remain_mem [TASK_SLOTS];

    logic [TIME_BITS-1:0]  time_reg;
    logic [TIME_BITS-1:0]  start_reg;
    logic [IDX_BITS-1:0]   idx_reg;

    logic                  best_v_reg;
    logic [IDX_BITS-1:0]   best_idx_reg;
    logic [BURST_BITS-1:0] best_rem_reg;
    logic [TIME_BITS-1:0]  best_arr_reg;
    logic [BURST_BITS-1:0] best_burst_reg;

    logic                  res_fin_reg;
    logic [TIME_BITS-1:0]  res_comp_reg;
    logic [CALC_BITS-1:0]  res_tat_reg;

    logic                  out_valid_reg;
    out_item_t             out_data_reg;

    logic                  load_ok;
    logic [IDX_BITS-1:0]   load_idx;
    logic                  cand;
    logic                  better;
    logic [TIME_BITS-1:0]  time_next;
    logic [BURST_BITS-1:0] rem_next;
    logic                  fin_next;
    logic [CALC_BITS-1:0]  burst_ext;
    logic [CALC_BITS-1:0]  wait_val;

    assign load_ok  = int'(in_data.slot) < TASK_SLOTS;
    assign load_idx = IDX_BITS'(in_data.slot);

    assign cand   = valid_reg[idx_reg] && pending_reg[idx_reg] &&
                    (arrival_mem[idx_reg] <= start_reg);
    assign better = !best_v_reg ||
                    (remain_mem[idx_reg] < best_rem_reg) ||
                    ((remain_mem[idx_reg] == best_rem_reg) &&
                     (arrival_mem[idx_reg] < best_arr_reg));

    assign time_next = (start_reg < TIME_MAX) ? start_reg + 1'b1 : start_reg;
    assign rem_next  = (best_rem_reg != '0) ? best_rem_reg - 1'b1 : best_rem_reg;
    assign fin_next  = best_v_reg && (rem_next == '0);

    assign burst_ext = CALC_BITS'(best_burst_reg);
    assign wait_val  = (res_tat_reg >= burst_ext) ? res_tat_reg - burst_ext : '0;

    assign status.scan_last = (idx_reg == IDX_LAST);
    assign status.out_free  = !out_valid_reg || out_ready;

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // slot table and flags
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg   <= '0;
            pending_reg <= '0;
        end else begin
            if (cmd.load && load_ok) begin
                valid_reg[load_idx]   <= 1'b1;
                pending_reg[load_idx] <= (in_data.burst != '0);
            end else if (cmd.update && fin_next) begin
                pending_reg[best_idx_reg] <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load && load_ok) begin
            arrival_mem[load_idx] <= TIME_BITS'(in_data.arrival);
            burst_mem[load_idx]   <= in_data.burst;
            remain_mem[load_idx]  <= in_data.burst;
        end else if (cmd.update && best_v_reg) begin
            remain_mem[best_idx_reg] <= rem_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            time_reg <= '0;
        end else if (cmd.update) begin
            time_reg <= time_next;
        end
    end

    // scan over the slots, one per cycle
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            best_v_reg <= 1'b0;
        end else if (cmd.tick_begin) begin
            best_v_reg <= 1'b0;
        end else if (cmd.scan && cand && better) begin
            best_v_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.tick_begin) begin
            start_reg <= time_reg;
            idx_reg   <= '0;
        end else if (cmd.scan) begin
            idx_reg <= idx_reg + 1'b1;
            if (cand && better) begin
                best_idx_reg   <= idx_reg;
                best_rem_reg   <= remain_mem[idx_reg];
                best_arr_reg   <= arrival_mem[idx_reg];
                best_burst_reg <= burst_mem[idx_reg];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.update) begin
            res_fin_reg  <= fin_next;
            res_comp_reg <= time_next;
            res_tat_reg  <= CALC_BITS'(time_next - best_arr_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.report) begin
            out_valid_reg <= 1'b1;
        end else if (out_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.report) begin
            out_data_reg.tick_start <= 24'(start_reg);
            out_data_reg.running    <= best_v_reg ? 4'(best_idx_reg) : 4'd0;
            out_data_reg.idle       <= !best_v_reg;
            out_data_reg.finished   <= res_fin_reg;
            out_data_reg.completion <= res_fin_reg ? 24'(res_comp_reg) : 24'd0;
            out_data_reg.turnaround <= res_fin_reg ? 24'(res_tat_reg) : 24'd0;
            out_data_reg.waiting    <= res_fin_reg ? 24'(wait_val) : 24'd0;
            out_data_reg.all_done   <= ~|(valid_reg & pending_reg);
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.report |-> (!out_valid_reg || out_ready))
        else $error("result overwritten before transfer");

    assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && out_data_reg.finished |-> !out_data_reg.idle)
        else $error("idle tick reports completion");

    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.update |=> time_reg >= $past(time_reg))
        else $error("time moved backward");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.update && fin_next) |=> !pending_reg[$past(best_idx_reg)])
        else $error("finished slot still pending");

endmodule

// File: hdl/srtf_tick_scheduler.sv
// Shortest-remaining-time-first tick scheduler.
//
// Input channel s_valid/s_ready/s_data carries load and tick items. A load
// writes a task slot (arrival, burst) and makes no result; the scheduler
// stays ready for the next item. A tick walks all TASK_SLOTS slots, one
// slot per cycle through a single compare unit, then updates the chosen
// slot and the time, then forms the result and offers it on m_valid/m_data
// from the output register. s_ready stays low from the tick's transfer
// until the result has been written, so no new item is taken during a tick.
// Back-to-back loads run at one per cycle.
//
// The result sits in an output register; a new item is taken while it
// waits. If m_ready stays low, a following tick holds in its final step
// until the previous result has been transferred.
//
// Reset (aresetn low, synchronous) clears all valid and pending flags, the
// time and m_valid. Slot contents and the output data are not cleared.
module srtf_tick_scheduler (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  srtf_pkg::in_item_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output srtf_pkg::out_item_t m_data
);
    import srtf_pkg::*;

    ctrl_cmd_t    cmd;
    ctrl_status_t status;

    srtf_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_opcode (s_data.opcode),
        .in_ready  (s_ready),
        .status    (status),
        .cmd       (cmd)
    );

    srtf_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_data   (s_data),
        .cmd       (cmd),
        .status    (status),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_data  (m_data)
    );

endmodule
